// ----- design/efe_pkg.sv -----
// Shared types, register indexes and the byte classifier for the
// escaped frame encoder. No dependencies.

package efe_pkg;

    // Register indexes on the configuration port (paddr[3:2]).
    localparam logic [1:0] REG_FLAG       = 2'd0;
    localparam logic [1:0] REG_ESCAPE     = 2'd1;
    localparam logic [1:0] REG_FLAG_SUB   = 2'd2;
    localparam logic [1:0] REG_ESCAPE_SUB = 2'd3;

    // Reset values of the marker registers.
    localparam logic [7:0] FLAG_RESET       = 8'h7E;
    localparam logic [7:0] ESCAPE_RESET     = 8'h7D;
    localparam logic [7:0] FLAG_SUB_RESET   = 8'h02;
    localparam logic [7:0] ESCAPE_SUB_RESET = 8'h01;

    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        CLS_PLAIN,
        CLS_FLAG,
        CLS_ESCAPE
    } byte_class_t;

    typedef struct packed {
        logic [7:0] flag;
        logic [7:0] escape;
        logic [7:0] flag_sub;
        logic [7:0] escape_sub;
    } cfg_t;

    // One classified input item as handed from the front to the back.
    typedef struct packed {
        logic        open;
        logic [7:0]  body;
        byte_class_t body_cls;
        logic        last;
        logic [7:0]  check;
        byte_class_t check_cls;
    } item_t;

    // A byte matching both markers counts as a flag.
    function automatic byte_class_t classify(input logic [7:0] b, input cfg_t cfg);
        byte_class_t cls;
        if (b == cfg.flag) begin
            cls = CLS_FLAG;
        end else if (b == cfg.escape) begin
            cls = CLS_ESCAPE;
        end else begin
            cls = CLS_PLAIN;
        end
        return cls;
    endfunction

endpackage

// ----- design/efe_front.sv -----
// Front end: accepts body bytes, tracks frame state and the running XOR,
// and classifies the body byte and the check byte. Depends on efe_pkg.

module efe_front (
    input  logic           clk,
    input  logic           rst_n,
    input  efe_pkg::cfg_t  cfg,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     in_body,
    input  logic           in_last,
    output logic           push,
    output efe_pkg::item_t push_item,
    input  logic           queue_full
);

    logic       frame_open_reg;
    logic       frame_open_next;
    logic [7:0] xor_reg;
    logic [7:0] xor_next;
    logic [7:0] xor_sum;
    logic       accept;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept;

    // A new frame starts the checksum from zero.
    assign xor_sum = (frame_open_reg ? xor_reg : 8'h00) ^ in_body;

    // Build the descriptor for the back end.
    always_comb
    begin
        push_item.open      = !frame_open_reg;
        push_item.body      = in_body;
        push_item.body_cls  = efe_pkg::classify(in_body, cfg);
        push_item.last      = in_last;
        push_item.check     = xor_sum;
        push_item.check_cls = efe_pkg::classify(xor_sum, cfg);
    end

    // Frame state advances on each accepted transaction.
    always_comb
    begin
        frame_open_next = frame_open_reg;
        xor_next        = xor_reg;
        if (accept) begin
            frame_open_next = !in_last;
            xor_next        = in_last ? 8'h00 : xor_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            frame_open_reg <= 1'b0;
            xor_reg        <= 8'h00;
        end else begin
            frame_open_reg <= frame_open_next;
            xor_reg        <= xor_next;
        end
    end

endmodule

// ----- design/efe_queue.sv -----
// Short FIFO of classified items between the front and the back end.
// Depends on efe_pkg.

module efe_queue #(
    parameter int DEPTH = efe_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  efe_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output efe_pkg::item_t head
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    efe_pkg::item_t mem [DEPTH];

    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;

    assign full  = (count_reg == CntW'(DEPTH));
    assign valid = (count_reg != '0);
    assign head  = mem[rd_ptr_reg];

    // Pointer and fill count update; push and pop may happen together.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- design/efe_back.sv -----
// Back end: walks each queued item through its output bytes, one byte per cycle
// unless the output stalls, into a registered output stage. Depends on efe_pkg.

module efe_back (
    input  logic           clk,
    input  logic           rst_n,
    input  efe_pkg::cfg_t  cfg,
    input  logic           head_valid,
    input  efe_pkg::item_t head,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_byte,
    output logic           out_run_end,
    output logic           out_frame_end
);

    typedef enum logic [2:0] {
        STEP_START,
        STEP_OPEN,
        STEP_BODY,
        STEP_BODY_SUB,
        STEP_CHECK,
        STEP_CHECK_SUB,
        STEP_CLOSE
    } step_t;

    step_t      step_reg;
    step_t      step_next;
    step_t      cur_step;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       run_end_reg;
    logic       frame_end_reg;
    logic       frame_end_next;
    logic       done;
    logic       advance;

    assign advance = head_valid && (!out_valid_reg || out_ready);
    assign pop     = advance && done;

    assign out_valid     = out_valid_reg;
    assign out_byte      = byte_reg;
    assign out_run_end   = run_end_reg;
    assign out_frame_end = frame_end_reg;

    // The first step of an item depends on whether it opens a frame.
    always_comb
    begin
        if (step_reg == STEP_START) begin
            cur_step = head.open ? STEP_OPEN : STEP_BODY;
        end else begin
            cur_step = step_reg;
        end
    end

    // Byte for the current step and the step that follows it.
    always_comb
    begin
        byte_next      = cfg.flag;
        frame_end_next = 1'b0;
        step_next      = STEP_START;
        done           = 1'b0;
        case (cur_step)
            STEP_OPEN:
            begin
                byte_next = cfg.flag;
                step_next = STEP_BODY;
            end
            STEP_BODY:
            begin
                if (head.body_cls == efe_pkg::CLS_PLAIN) begin
                    byte_next = head.body;
                    step_next = head.last ? STEP_CHECK : STEP_START;
                    done      = !head.last;
                end else begin
                    byte_next = cfg.escape;
                    step_next = STEP_BODY_SUB;
                end
            end
            STEP_BODY_SUB:
            begin
                byte_next = (head.body_cls == efe_pkg::CLS_FLAG) ? cfg.flag_sub
                                                                 : cfg.escape_sub;
                step_next = head.last ? STEP_CHECK : STEP_START;
                done      = !head.last;
            end
            STEP_CHECK:
            begin
                if (head.check_cls == efe_pkg::CLS_PLAIN) begin
                    byte_next = head.check;
                    step_next = STEP_CLOSE;
                end else begin
                    byte_next = cfg.escape;
                    step_next = STEP_CHECK_SUB;
                end
            end
            STEP_CHECK_SUB:
            begin
                byte_next = (head.check_cls == efe_pkg::CLS_FLAG) ? cfg.flag_sub
                                                                  : cfg.escape_sub;
                step_next = STEP_CLOSE;
            end
            STEP_CLOSE:
            begin
                byte_next      = cfg.flag;
                frame_end_next = 1'b1;
                step_next      = STEP_START;
                done           = 1'b1;
            end
            default:
            begin
                step_next = STEP_START;
            end
        endcase
    end

    // The output stage holds its transaction until it is taken.
    always_comb
    begin
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            step_reg      <= STEP_START;
            out_valid_reg <= 1'b0;
            byte_reg      <= 8'h00;
            run_end_reg   <= 1'b0;
            frame_end_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (advance) begin
                step_reg      <= step_next;
                byte_reg      <= byte_next;
                run_end_reg   <= done;
                frame_end_reg <= frame_end_next;
            end
        end
    end

endmodule

// ----- design/escaped_frame_encoder_xor_bcc.sv -----
// Top level of the escaped frame encoder with XOR block check: marker
// registers on the configuration port, front end, queue and back end.
// Depends on efe_pkg, efe_front, efe_queue and efe_back.
//
//  Channel   Direction  Content
//  s_axis    in         tdata = body_byte, tlast = last_byte
//  m_axis    out        tdata = line_byte, tlast = run_end, tuser = frame_end
//  apb       in/out     marker registers at 0x0, 0x4, 0x8, 0xC
//
// The output sends one byte per cycle unless m_axis_tready stalls it; an item
// yields 1 to 6 bytes (one for a plain mid-frame byte).
// The front accepts one byte per cycle while the queue of QUEUE_DEPTH items
// has room; the back end's output register sets the sustained rate.
// rst_n clears frame state, the queue and the output stage at once.
// A stalled output backs up the queue, then the input.

module escaped_frame_encoder_xor_bcc #(
    parameter int QUEUE_DEPTH = efe_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] body_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] line_byte
    output logic        m_axis_tlast,
    output logic        m_axis_tuser,   // [0] frame_end
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    efe_pkg::cfg_t  cfg_reg;
    efe_pkg::item_t push_item;
    efe_pkg::item_t head;
    logic           push;
    logic           pop;
    logic           queue_full;
    logic           head_valid;
    logic           cfg_write;
    logic [1:0]     reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // Marker registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.flag       <= efe_pkg::FLAG_RESET;
            cfg_reg.escape     <= efe_pkg::ESCAPE_RESET;
            cfg_reg.flag_sub   <= efe_pkg::FLAG_SUB_RESET;
            cfg_reg.escape_sub <= efe_pkg::ESCAPE_SUB_RESET;
        end else if (cfg_write) begin
            case (reg_index)
                efe_pkg::REG_FLAG:       cfg_reg.flag       <= pwdata[7:0];
                efe_pkg::REG_ESCAPE:     cfg_reg.escape     <= pwdata[7:0];
                efe_pkg::REG_FLAG_SUB:   cfg_reg.flag_sub   <= pwdata[7:0];
                efe_pkg::REG_ESCAPE_SUB: cfg_reg.escape_sub <= pwdata[7:0];
                default:                 cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (reg_index)
            efe_pkg::REG_FLAG:       prdata = {24'h0, cfg_reg.flag};
            efe_pkg::REG_ESCAPE:     prdata = {24'h0, cfg_reg.escape};
            efe_pkg::REG_FLAG_SUB:   prdata = {24'h0, cfg_reg.flag_sub};
            efe_pkg::REG_ESCAPE_SUB: prdata = {24'h0, cfg_reg.escape_sub};
            default:                 prdata = 32'h0;
        endcase
    end

    efe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_body    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    efe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .valid     (head_valid),
        .head      (head)
    );

    efe_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .head_valid    (head_valid),
        .head          (head),
        .pop           (pop),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_byte      (m_axis_tdata),
        .out_run_end   (m_axis_tlast),
        .out_frame_end (m_axis_tuser)
    );

endmodule

// ----- design/efe_checker.sv -----
// Port-level checks for the escaped frame encoder, bound to the top level.
// Depends only on the top level's ports.

module efe_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser,
    input logic        pready
);

    // A closing flag always ends the run of its input byte.
    a_frame_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("closing flag without end of run");

    // A closing flag is never sent twice in a row.
    a_no_double_close: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tuser
        |=> !(m_axis_tvalid && m_axis_tuser))
        else $error("two closing flags in a row");

    // The configuration port never waits.
    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

    // A stalled output transaction holds its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("output changed while stalled");

endmodule

bind escaped_frame_encoder_xor_bcc efe_checker u_efe_checker (.*);

// ----- tb/escaped_frame_encoder_xor_bcc_tb.sv -----
// Self-checking testbench for escaped_frame_encoder_xor_bcc: frames of body bytes under
// several marker settings, checked byte by byte against an in-bench framing predictor.
// Depends on efe_pkg and the escaped_frame_encoder_xor_bcc RTL.

module escaped_frame_encoder_xor_bcc_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned DRAIN_CYCLES = 20;

    typedef struct {
        logic [7:0] body;
        logic       last;
    } body_item_t;

    typedef struct {
        logic [7:0] line_byte;
        logic       run_end;
        logic       frame_end;
    } line_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] body_byte
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;           // [7:0] line_byte
    logic        m_axis_tlast;
    logic        m_axis_tuser;           // [0] frame_end
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'h0;
    logic [31:0] pwdata = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    // Marker registers and frame state as the predictor sees them.
    efe_pkg::cfg_t marker_cfg = '{flag: efe_pkg::FLAG_RESET, escape: efe_pkg::ESCAPE_RESET,
                                  flag_sub: efe_pkg::FLAG_SUB_RESET,
                                  escape_sub: efe_pkg::ESCAPE_SUB_RESET};
    logic        frame_open = 1'b0;
    logic [7:0]  running_check = 8'h00;

    body_item_t  body_pending[$];
    line_item_t  line_expect[$];

    // Running check of the bytes queued so far, used to aim checks at the markers.
    logic [7:0]  queued_check = 8'h00;

    int unsigned cycle_count = 0;
    int unsigned error_count = 0;
    int unsigned bytes_in = 0;
    int unsigned frames_in = 0;
    int unsigned lines_checked = 0;
    int unsigned settings_used = 1;

    int unsigned src_gap = 0;
    int unsigned sink_wait = 0;
    bit          src_calm = 1'b0;
    bit          sink_calm = 1'b0;
    body_item_t  next_body;
    line_item_t  want_line;

    escaped_frame_encoder_xor_bcc dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Clock generation.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d line bytes still expected",
                     cycle_count, line_expect.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
        begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
    endtask

    // Expected line bytes for one body transaction.
    function automatic void push_line(input logic [7:0] b, input logic fend);
        line_item_t e;
        e.line_byte = b;
        e.run_end = 1'b0;
        e.frame_end = fend;
        line_expect = {line_expect, e};
    endfunction

    // A flag match wins over an escape match when both markers are equal.
    function automatic void push_stuffed(input logic [7:0] b);
        if (b == marker_cfg.flag)
        begin
            push_line(marker_cfg.escape, 1'b0);
            push_line(marker_cfg.flag_sub, 1'b0);
        end
        else if (b == marker_cfg.escape)
        begin
            push_line(marker_cfg.escape, 1'b0);
            push_line(marker_cfg.escape_sub, 1'b0);
        end
        else
        begin
            push_line(b, 1'b0);
        end
    endfunction

    function automatic void encode_body_byte(input logic [7:0] b, input logic last);
        if (!frame_open)
        begin
            push_line(marker_cfg.flag, 1'b0);
            frame_open = 1'b1;
            running_check = 8'h00;
        end
        push_stuffed(b);
        running_check = running_check ^ b;
        if (last)
        begin
            push_stuffed(running_check);
            push_line(marker_cfg.flag, 1'b1);
            frame_open = 1'b0;
            running_check = 8'h00;
        end
        line_expect[line_expect.size() - 1].run_end = 1'b1;
    endfunction

    // Stimulus generation.
    function automatic void queue_body(input logic [7:0] b, input logic last);
        body_item_t it;
        it.body = b;
        it.last = last;
        body_pending = {body_pending, it};
        queued_check = last ? 8'h00 : (queued_check ^ b);
    endfunction

    // Body bytes lean toward the current markers and substitutes.
    function automatic logic [7:0] pick_byte();
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0: b = marker_cfg.flag;
            1: b = marker_cfg.escape;
            2: b = marker_cfg.flag_sub;
            3: b = marker_cfg.escape_sub;
            default: b = 8'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    function automatic void queue_random_frames(input int unsigned budget);
        int unsigned made;
        int unsigned len;
        logic [7:0]  b;
        made = 0;
        while (made < budget)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            for (int unsigned i = 0; i < len; i++)
            begin
                b = pick_byte();
                // Now and then the closing byte is chosen so the check hits a marker.
                if (i == len - 1 && $urandom_range(0, 3) == 0)
                begin
                    b = queued_check ^ ($urandom_range(0, 1) ? marker_cfg.flag
                                                             : marker_cfg.escape);
                end
                queue_body(b, i == len - 1);
            end
            made += len;
        end
    endfunction

    task automatic wait_drained();
        while (body_pending.size() != 0 || s_axis_tvalid || line_expect.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Write one marker register, then read it back.
    task automatic set_marker(input logic [1:0] idx, input logic [7:0] val);
        logic [31:0] seen;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'($urandom), val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            efe_pkg::REG_FLAG:       marker_cfg.flag = val;
            efe_pkg::REG_ESCAPE:     marker_cfg.escape = val;
            efe_pkg::REG_FLAG_SUB:   marker_cfg.flag_sub = val;
            efe_pkg::REG_ESCAPE_SUB: marker_cfg.escape_sub = val;
            default: ;
        endcase
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        seen = prdata;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (seen[7:0] !== val)
        begin
            note_failure($sformatf("register %0d read back 0x%02h, expected 0x%02h",
                                   idx, seen[7:0], val));
        end
    endtask

    task automatic set_markers(input logic [7:0] flag, input logic [7:0] esc,
                               input logic [7:0] flag_sub, input logic [7:0] esc_sub);
        set_marker(efe_pkg::REG_FLAG, flag);
        set_marker(efe_pkg::REG_ESCAPE, esc);
        set_marker(efe_pkg::REG_FLAG_SUB, flag_sub);
        set_marker(efe_pkg::REG_ESCAPE_SUB, esc_sub);
        settings_used++;
    endtask

    // Source side: one body transaction at a time, with random gaps between them.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= 8'h00;
            s_axis_tlast <= 1'b0;
            src_gap = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                encode_body_byte(s_axis_tdata, s_axis_tlast);
                bytes_in++;
                if (s_axis_tlast)
                begin
                    frames_in++;
                end
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (src_gap == 0 && body_pending.size() != 0)
                begin
                    next_body = body_pending.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= next_body.body;
                    s_axis_tlast <= next_body.last;
                    if ($urandom_range(0, 29) == 0)
                    begin
                        src_calm = !src_calm;
                    end
                    src_gap = src_calm ? 0 : $urandom_range(0, 7);
                end
                else
                begin
                    if (src_gap != 0)
                    begin
                        src_gap--;
                    end
                    s_axis_tvalid <= 1'b0;
                    s_axis_tdata <= 8'($urandom);
                    s_axis_tlast <= 1'($urandom_range(0, 1));
                end
            end
        end
    end

    // Sink side: check each line byte, then stall for a random number of cycles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_wait = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                lines_checked++;
                if (line_expect.size() == 0)
                begin
                    note_failure($sformatf("unexpected line byte 0x%02h last=%0b end=%0b",
                                           m_axis_tdata, m_axis_tlast, m_axis_tuser));
                end
                else
                begin
                    want_line = line_expect.pop_front();
                    if (m_axis_tdata !== want_line.line_byte || m_axis_tlast !== want_line.run_end
                        || m_axis_tuser !== want_line.frame_end)
                    begin
                        note_failure($sformatf(
                            "line byte 0x%02h last=%0b end=%0b, expected 0x%02h last=%0b end=%0b",
                            m_axis_tdata, m_axis_tlast, m_axis_tuser, want_line.line_byte,
                            want_line.run_end, want_line.frame_end));
                    end
                end
                if ($urandom_range(0, 39) == 0)
                begin
                    sink_calm = !sink_calm;
                end
                sink_wait = sink_calm ? 0 : $urandom_range(0, 7);
            end
            else if (sink_wait != 0)
            begin
                sink_wait--;
            end
            m_axis_tready <= (sink_wait == 0);
        end
    end

    // Test sequence: reset, then phases of traffic under different marker settings.
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset markers: single-byte frames at the extremes and on both markers.
        queue_body(8'h00, 1'b1);
        queue_body(8'hFF, 1'b1);
        queue_body(efe_pkg::FLAG_RESET, 1'b1);
        queue_body(efe_pkg::ESCAPE_RESET, 1'b1);
        // Markers, substitutes and extremes inside one frame.
        queue_body(efe_pkg::FLAG_RESET, 1'b0);
        queue_body(efe_pkg::ESCAPE_RESET, 1'b0);
        queue_body(efe_pkg::ESCAPE_SUB_RESET, 1'b0);
        queue_body(efe_pkg::FLAG_SUB_RESET, 1'b0);
        queue_body(8'h00, 1'b0);
        queue_body(8'hFF, 1'b1);
        // Checks that land on the flag and on the escape.
        queue_body(efe_pkg::FLAG_RESET ^ 8'h02, 1'b0);
        queue_body(8'h02, 1'b1);
        queue_body(efe_pkg::ESCAPE_RESET ^ 8'h01, 1'b0);
        queue_body(8'h01, 1'b1);
        queue_random_frames(50);
        // Leave a frame open across the next register change.
        queue_body(8'h11, 1'b0);
        queue_body(efe_pkg::FLAG_RESET, 1'b0);
        wait_drained();

        // Extremes, with substitutes equal to the other marker.
        set_markers(8'h00, 8'hFF, 8'hFF, 8'h00);
        queue_random_frames(40);
        wait_drained();

        // Flag and escape equal: a matching byte is escaped as a flag.
        set_markers(8'h55, 8'h55, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        queue_body(8'h55, 1'b1);
        queue_body(8'h54, 1'b0);
        queue_body(8'h01, 1'b1);
        queue_random_frames(40);
        wait_drained();

        // Opposite extremes.
        set_markers(8'hFF, 8'h00, 8'h00, 8'hFF);
        queue_random_frames(40);
        wait_drained();

        // Random marker sets.
        for (int k = 0; k < 2; k++)
        begin
            set_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            queue_random_frames(30);
            wait_drained();
        end

        // Back to the reset values, written explicitly.
        set_markers(efe_pkg::FLAG_RESET, efe_pkg::ESCAPE_RESET,
                    efe_pkg::FLAG_SUB_RESET, efe_pkg::ESCAPE_SUB_RESET);
        queue_random_frames(30);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (line_expect.size() != 0)
        begin
            note_failure($sformatf("%0d line bytes never arrived", line_expect.size()));
        end

        $display("Sent %0d body bytes in %0d closed frames over %0d marker settings.",
                 bytes_in, frames_in, settings_used);
        $display("Checked %0d line bytes, %0d failures.", lines_checked, error_count);
        if (error_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/efe_pkg.sv
design/efe_front.sv
design/efe_queue.sv
design/efe_back.sv
design/escaped_frame_encoder_xor_bcc.sv
design/efe_checker.sv
tb/escaped_frame_encoder_xor_bcc_tb.sv
